// ===== hdl/cicd_pkg.sv =====
// ----------------------------------------------------------------------------
// CIC decimator package
// Fixed widths, limits and the reset value of the decimation register.
// ----------------------------------------------------------------------------
`default_nettype none

package cicd_pkg;

    // Decimation register and phase counter widths.
    localparam int DECIM_W = 7;
    localparam int PHASE_W = 6;

    // Legal span of the rate divider and its value after reset.
    localparam logic [DECIM_W-1:0] DECIM_MIN   = 7'd1;
    localparam logic [DECIM_W-1:0] DECIM_MAX   = 7'd64;
    localparam logic [DECIM_W-1:0] DECIM_RESET = 7'd16;

    typedef logic [DECIM_W-1:0] decim_t;
    typedef logic [PHASE_W-1:0] phase_t;

endpackage : cicd_pkg

`default_nettype wire

// ===== hdl/cicd_integ_cell.sv =====
// ----------------------------------------------------------------------------
// CIC integrator cell
// One integrator stage for both the real and imaginary paths, with its own
// valid bit so that the chain can hold or collapse bubbles.
// ----------------------------------------------------------------------------
`default_nettype none

module cicd_integ_cell #(
    parameter int ACC_WIDTH = 34
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [ACC_WIDTH-1:0] in_re,
    input  wire logic [ACC_WIDTH-1:0] in_im,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [ACC_WIDTH-1:0]      out_re,
    output logic [ACC_WIDTH-1:0]      out_im
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [ACC_WIDTH-1:0] acc_re_reg;
    logic [ACC_WIDTH-1:0] acc_re_next;
    logic [ACC_WIDTH-1:0] acc_im_reg;
    logic [ACC_WIDTH-1:0] acc_im_next;
    logic                 take;

    // The accumulator is both the stage state and the value handed on, so
    // it may only move once the item it currently shows has been taken.
    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        valid_next  = valid_reg && !out_ready;
        if (take)
        begin
            acc_re_next = acc_re_reg + in_re;
            acc_im_next = acc_im_reg + in_im;
            valid_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_re    = acc_re_reg;
    assign out_im    = acc_im_reg;

endmodule : cicd_integ_cell

`default_nettype wire

// ===== hdl/cicd_comb_cell.sv =====
// ----------------------------------------------------------------------------
// CIC comb cell
// One unit-delay comb stage for both paths: y = x - previous x, wrapping.
// ----------------------------------------------------------------------------
`default_nettype none

module cicd_comb_cell #(
    parameter int ACC_WIDTH = 34
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [ACC_WIDTH-1:0] in_re,
    input  wire logic [ACC_WIDTH-1:0] in_im,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [ACC_WIDTH-1:0]      out_re,
    output logic [ACC_WIDTH-1:0]      out_im
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [ACC_WIDTH-1:0] dly_re_reg;
    logic [ACC_WIDTH-1:0] dly_im_reg;
    logic [ACC_WIDTH-1:0] y_re_reg;
    logic [ACC_WIDTH-1:0] y_im_reg;
    logic                 take;

    assign in_ready   = !valid_reg || out_ready;
    assign take       = in_valid && in_ready;
    assign valid_next = take || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            dly_re_reg <= '0;
            dly_im_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (take)
            begin
                dly_re_reg <= in_re;
                dly_im_reg <= in_im;
            end
        end
    end

    // Result registers carry payload only.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            y_re_reg <= in_re - dly_re_reg;
            y_im_reg <= in_im - dly_im_reg;
        end
    end

    assign out_valid = valid_reg;
    assign out_re    = y_re_reg;
    assign out_im    = y_im_reg;

endmodule : cicd_comb_cell

`default_nettype wire

// ===== hdl/cic_decimator_complex.sv =====
// ----------------------------------------------------------------------------
// Complex CIC decimator
// Real and imaginary CIC decimation with a run-time rate divider.
// ----------------------------------------------------------------------------
// The block takes one complex sample per cycle while in_ready is high and
// gives one complex result for every R samples accepted, R being the
// decimation register (a value of zero behaves as one and values above 64
// behave as 64). The samples run through a row of STAGES integrator cells
// and, for kept samples, a row of STAGES comb cells, each cell being one
// register stage. Every cell has its own valid bit, so a stalled output
// only holds up the input once every cell in the row is full; until then
// new items keep flowing in and fill the bubbles. All accumulators and comb
// delays wrap modulo 2^ACC_WIDTH and are cleared at reset, as is the group
// position. The first sample of each group is the one kept. The decimation
// register should only be written while the block is empty; a group in
// progress keeps its position and wraps once the next position reaches or
// passes the new R.
// ----------------------------------------------------------------------------
`default_nettype none

module cic_decimator_complex
    import cicd_pkg::*;
#(
    parameter int STAGES       = 3,
    parameter int SAMPLE_WIDTH = 16,
    parameter int ACC_WIDTH    = 34
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Configuration
    input  wire logic                           cfg_we,
    input  wire logic [DECIM_W-1:0]             cfg_wdata,
    // Input channel
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_real,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_imag,
    // Output channel
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [ACC_WIDTH-1:0]         out_real,
    output logic signed [ACC_WIDTH-1:0]         out_imag
);

    // Handshake and data wires joining the cells. Index k is the input of
    // cell k; index STAGES is the output of the last cell.
    logic                 iv   [STAGES+1];
    logic                 ir   [STAGES+1];
    logic [ACC_WIDTH-1:0] ire  [STAGES+1];
    logic [ACC_WIDTH-1:0] iim  [STAGES+1];

    logic                 cv   [STAGES+1];
    logic                 cr   [STAGES+1];
    logic [ACC_WIDTH-1:0] cre  [STAGES+1];
    logic [ACC_WIDTH-1:0] cim  [STAGES+1];

    decim_t               decim_reg;
    decim_t               decim_eff;
    phase_t               phase_reg;
    phase_t               phase_next;
    logic [DECIM_W-1:0]   phase_inc;
    logic                 keep;
    logic                 int_take;

    // ------------------------------------------------------------------
    // Decimation register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            decim_reg <= DECIM_RESET;
        else if (cfg_we)
            decim_reg <= cfg_wdata;
    end

    // Out-of-range settings are clamped to the legal span.
    always_comb
    begin
        priority if (decim_reg < DECIM_MIN)
            decim_eff = DECIM_MIN;
        else if (decim_reg > DECIM_MAX)
            decim_eff = DECIM_MAX;
        else
            decim_eff = decim_reg;
    end

    // ------------------------------------------------------------------
    // Integrator row. Samples are sign-extended into the first cell.
    // ------------------------------------------------------------------
    assign iv[0]    = in_valid;
    assign in_ready = ir[0];
    assign ire[0]   = ACC_WIDTH'(sample_real);
    assign iim[0]   = ACC_WIDTH'(sample_imag);

    for (genvar k = 0; k < STAGES; k++)
    begin : g_integ
        cicd_integ_cell #(
            .ACC_WIDTH (ACC_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (iv[k]),
            .in_ready  (ir[k]),
            .in_re     (ire[k]),
            .in_im     (iim[k]),
            .out_valid (iv[k+1]),
            .out_ready (ir[k+1]),
            .out_re    (ire[k+1]),
            .out_im    (iim[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Rate divider. Every integrated item leaving the last integrator
    // advances the group position; only the first of a group is passed to
    // the comb row, the others are dropped at once.
    // ------------------------------------------------------------------
    assign keep        = (phase_reg == '0);
    assign cv[0]       = iv[STAGES] && keep;
    assign cre[0]      = ire[STAGES];
    assign cim[0]      = iim[STAGES];
    assign ir[STAGES]  = keep ? cr[0] : 1'b1;
    assign int_take    = iv[STAGES] && ir[STAGES];
    assign phase_inc   = {1'b0, phase_reg} + DECIM_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        if (int_take)
        begin
            if (phase_inc >= decim_eff)
                phase_next = '0;
            else
                phase_next = phase_inc[PHASE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else
            phase_reg <= phase_next;
    end

    // ------------------------------------------------------------------
    // Comb row. The last cell's result register drives the output.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < STAGES; k++)
    begin : g_comb
        cicd_comb_cell #(
            .ACC_WIDTH (ACC_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cv[k]),
            .in_ready  (cr[k]),
            .in_re     (cre[k]),
            .in_im     (cim[k]),
            .out_valid (cv[k+1]),
            .out_ready (cr[k+1]),
            .out_re    (cre[k+1]),
            .out_im    (cim[k+1])
        );
    end

    assign out_valid  = cv[STAGES];
    assign cr[STAGES] = out_ready;
    assign out_real   = $signed(cre[STAGES]);
    assign out_imag   = $signed(cim[STAGES]);

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The input can only be held off when the first integrator still shows
    // an item that its neighbour has not taken.
    a_ready_backed: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (iv[1] && !ir[1]))
        else $error("input stalled with a free first integrator");

    // With a rate of one every item is kept, so the position stays at zero.
    a_rate_one: assert property (@(posedge clk) disable iff (!rst_n)
        (int_take && decim_eff == DECIM_MIN && !cfg_we) |=> (phase_reg == '0))
        else $error("group position moved at a rate of one");

    // An item in the middle of a group never reaches the comb row.
    a_drop_mid_group: assert property (@(posedge clk) disable iff (!rst_n)
        (iv[STAGES] && phase_reg != '0) |-> !cv[0])
        else $error("non-first item of a group passed to the combs");

endmodule : cic_decimator_complex

`default_nettype wire

// ===== tb/cic_decimator_complex_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex CIC decimator checker
// Watches the configuration, input and output channels of the decimator,
// predicts each decimated result from the accepted samples and compares
// the results that leave the block, in order, field by field.
// ----------------------------------------------------------------------------

module cic_decimator_complex_checker
    import cicd_pkg::*;
#(
    parameter int STAGES       = 3,
    parameter int SAMPLE_WIDTH = 16,
    parameter int ACC_WIDTH    = 34
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [DECIM_W-1:0]             cfg_wdata,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_real,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_imag,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic signed [ACC_WIDTH-1:0]    out_real,
    input  logic signed [ACC_WIDTH-1:0]    out_imag,
    output int                             mismatch_count,
    output int                             pending_results
);

    typedef struct packed {
        logic signed [ACC_WIDTH-1:0] re;
        logic signed [ACC_WIDTH-1:0] im;
    } cic_result_t;

    // Index 0 is the real path, index 1 the imaginary path.
    logic [ACC_WIDTH-1:0] integ_acc [2][STAGES];
    logic [ACC_WIDTH-1:0] comb_dly  [2][STAGES];
    phase_t               group_pos;
    decim_t               rate_reg;
    cic_result_t          decimated_q [$];

    // Runs one accepted sample through the integrators and, on the first
    // sample of a group, through the combs as well.
    task automatic advance_filter(input logic signed [SAMPLE_WIDTH-1:0] s_re,
                                  input logic signed [SAMPLE_WIDTH-1:0] s_im);
        logic [ACC_WIDTH-1:0] x [2];
        logic [ACC_WIDTH-1:0] y;
        int                   r;
        bit                   keep;
        cic_result_t          res;
        x[0] = ACC_WIDTH'(s_re);
        x[1] = ACC_WIDTH'(s_im);
        r = int'(rate_reg);
        if (r == 0)
            r = 1;
        if (r > int'(DECIM_MAX))
            r = int'(DECIM_MAX);
        for (int p = 0; p < 2; p++)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                integ_acc[p][k] = integ_acc[p][k] + x[p];
                x[p] = integ_acc[p][k];
            end
        end
        keep = (group_pos == 0);
        if (int'(group_pos) + 1 >= r)
            group_pos = '0;
        else
            group_pos = group_pos + 1'b1;
        if (keep)
        begin
            for (int p = 0; p < 2; p++)
            begin
                for (int k = 0; k < STAGES; k++)
                begin
                    y = x[p] - comb_dly[p][k];
                    comb_dly[p][k] = x[p];
                    x[p] = y;
                end
            end
            res.re = x[0];
            res.im = x[1];
            decimated_q.push_back(res);
        end
    endtask

    task automatic report_mismatch(input string field,
                                   input logic signed [ACC_WIDTH-1:0] want,
                                   input logic signed [ACC_WIDTH-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        cic_result_t want;
        if (!rst_n)
        begin
            for (int p = 0; p < 2; p++)
            begin
                for (int k = 0; k < STAGES; k++)
                begin
                    integ_acc[p][k] = '0;
                    comb_dly[p][k]  = '0;
                end
            end
            group_pos = '0;
            rate_reg = DECIM_RESET;
            decimated_q.delete();
            mismatch_count = 0;
            pending_results = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (decimated_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result re=%0d im=%0d", $realtime,
                                 out_real, out_imag);
                end
                else
                begin
                    want = decimated_q.pop_front();
                    if (out_real !== want.re)
                        report_mismatch("out_real", want.re, out_real);
                    if (out_imag !== want.im)
                        report_mismatch("out_imag", want.im, out_imag);
                end
            end
            if (in_valid && in_ready)
                advance_filter(sample_real, sample_imag);
            if (cfg_we)
                rate_reg = cfg_wdata;
            pending_results = decimated_q.size();
        end
    end

endmodule

// ===== tb/cic_decimator_complex_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex CIC decimator testbench
// Drives sample items at random rates through a range of decimation
// settings, stalls the output side at random, and leaves the prediction and
// comparison of every result to the checker instantiated beside the block.
// ----------------------------------------------------------------------------

module cic_decimator_complex_tb;
    import cicd_pkg::*;

    localparam int STAGES       = 3;
    localparam int SAMPLE_WIDTH = 16;
    localparam int ACC_WIDTH    = 34;

    // Drain time covers the integrator and comb rows a result passes; the margin
    // covers samples still travelling through the integrators.
    localparam int DRAIN_CYCLES = 2 * STAGES + 10;
    // No handshake for this many cycles means the block has hung.
    localparam int STALL_LIMIT  = 4000;
    localparam int ITEM_TARGET  = 550;

    // Ways of filling the samples of one phase.
    typedef enum int {
        FILL_RANDOM,
        FILL_HIGH,
        FILL_LOW,
        FILL_EXTREME
    } fill_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    decim_t                         cfg_wdata;
    logic                           in_valid;
    logic                           in_ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_real;
    logic signed [SAMPLE_WIDTH-1:0] sample_imag;
    logic                           out_valid;
    logic                           out_ready;
    logic signed [ACC_WIDTH-1:0]    out_real;
    logic signed [ACC_WIDTH-1:0]    out_imag;

    int mismatch_count;
    int pending_results;
    int items_sent;
    int quiet_cycles;
    bit in_taken;
    // While set, neither side idles.
    bit calm;

    cic_decimator_complex #(
        .STAGES       (STAGES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample_real (sample_real),
        .sample_imag (sample_imag),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_real    (out_real),
        .out_imag    (out_imag)
    );

    cic_decimator_complex_checker #(
        .STAGES       (STAGES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sample_real     (sample_real),
        .sample_imag     (sample_imag),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_real        (out_real),
        .out_imag        (out_imag),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // The handshake is sampled at the rising edge and read by the driving
    // process at the following falling edge, so nothing races.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= in_valid && in_ready;
        end
    end

    // The receiver stalls at random, about 11 percent of the time, unless calm.
    always @(negedge clk)
    begin
        out_ready <= calm || ($urandom_range(0, 99) >= 11);
    end

    // Watchdog: counts cycles in which neither channel moves an item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one sample item and returns at the falling edge after it was
    // accepted. Valid is left high, so the next item follows without a gap
    // unless the random idling chooses one.
    task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] re,
                               input logic signed [SAMPLE_WIDTH-1:0] im);
        while (!calm && $urandom_range(0, 99) < 11)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        sample_real <= re;
        sample_imag <= im;
        @(negedge clk);
        while (!in_taken)
            @(negedge clk);
        items_sent++;
    endtask

    // Lets the block drain: every predicted result must have left, then the
    // pipeline gets time to finish samples that give no result.
    task automatic drain_block();
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_rate(input decim_t value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample(input fill_t fill);
        logic signed [SAMPLE_WIDTH-1:0] v;
        case (fill)
            FILL_HIGH:    v = SAMPLE_WIDTH'($urandom_range(30000, 32767));
            FILL_LOW:     v = SAMPLE_WIDTH'(-int'($urandom_range(30000, 32768)));
            FILL_EXTREME: v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default:      v = SAMPLE_WIDTH'($urandom);
        endcase
        return v;
    endfunction

    // Full-scale corners and bit patterns for the directed part.
    logic signed [SAMPLE_WIDTH-1:0] corner_re [8];
    logic signed [SAMPLE_WIDTH-1:0] corner_im [8];

    initial
    begin : stimulus
        int    rate;
        int    span;
        int    phase_no;
        fill_t fill;

        corner_re = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff,
                      16'sh0001, 16'sh7fff, 16'sh8000, 16'sh5555};
        corner_im = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff,
                      16'sh0001, 16'sh7fff, 16'sh8000, 16'shaaaa};

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        sample_real = '0;
        sample_imag = '0;
        calm        = 1'b0;
        items_sent  = 0;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. First the corners at the rate the block wakes up
        // with, then at a rate of zero, which must act as one.
        for (int i = 0; i < 8; i++)
            send_sample(corner_re[i], corner_im[i]);
        drain_block();
        write_rate(7'd0);
        for (int i = 0; i < 8; i++)
            send_sample(corner_re[i], corner_im[i]);

        // A rate above the limit, left part way through a group; the next
        // rate is smaller than the group position, so the group must wrap.
        drain_block();
        write_rate(7'd127);
        for (int i = 0; i < 6; i++)
            send_sample(corner_re[i], corner_im[i]);
        drain_block();
        write_rate(7'd5);

        // Random phases, each with its own rate, length and kind of sample.
        phase_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (phase_no > 0)
            begin
                drain_block();
                case ($urandom_range(0, 9))
                    0:       rate = 0;
                    1:       rate = 1;
                    2:       rate = int'(DECIM_MAX);
                    3:       rate = 127;
                    4:       rate = 65;
                    5:       rate = $urandom_range(0, 127);
                    default: rate = $urandom_range(2, 12);
                endcase
                write_rate(decim_t'(rate));
            end
            else
            begin
                rate = 5;
            end
            if (rate == 0)
                rate = 1;
            if (rate > int'(DECIM_MAX))
                rate = int'(DECIM_MAX);
            span = $urandom_range(1, 3 * rate + 2);
            if (span > ITEM_TARGET - items_sent)
                span = ITEM_TARGET - items_sent;
            case ($urandom_range(0, 7))
                5:       fill = FILL_HIGH;
                6:       fill = FILL_LOW;
                7:       fill = FILL_EXTREME;
                default: fill = FILL_RANDOM;
            endcase
            // A few phases in the middle run with no idling on either side.
            calm = (phase_no >= 4 && phase_no <= 6);
            for (int i = 0; i < span; i++)
                send_sample(pick_sample(fill), pick_sample(fill));
            phase_no++;
        end
        calm = 1'b0;

        // Let everything drain; the watchdog guards against a hang here.
        drain_block();

        if (mismatch_count == 0 && pending_results == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
